>>> src/sstk_pkg.sv
// shared types, codes and constants for the sortable stack
package sstk_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int WORD_W        = 32;
   localparam int FILL_W        = 5;

   // request codes
   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_POP  = 2'd1;
   localparam logic [1:0] REQ_SORT = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [WORD_W-1:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pop_value;
      logic [1:0]               status;
      logic [FILL_W-1:0]        fill_level;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic rsp_now;    // load the result of a request that finishes in its accept cycle
      logic push_wr;    // write push value on top
      logic pop_rd;     // read top entry and drop it
      logic sort_init;  // start outer pass at position 0
      logic hold_load;  // latch entry i into the hold register
      logic cmp_step;   // compare hold with entry j, exchange if smaller
      logic wb_step;    // write hold back to position i
      logic rsp_pop;    // load popped word as result
      logic rsp_done;   // load sort completion result
   } sstk_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic short_stack; // fewer than two entries
      logic j_last;
      logic i_last;
   } sstk_stat_type;

endpackage

>>> src/sstk_dp.sv
// sortable stack datapath: entry memory, fill count, sort indexes and result register
module sstk_dp #(
   parameter int DEPTH = sstk_pkg::DEFAULT_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sstk_pkg::req_item_type req_data,
   input  sstk_pkg::sstk_cmd_type cmd,
   output sstk_pkg::sstk_stat_type stat,
   output sstk_pkg::rsp_item_type rsp_data
);
   import sstk_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [WORD_W-1:0] mem [DEPTH];

   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            i_ff, i_in;
   logic [AW-1:0]            j_ff, j_in;
   logic signed [WORD_W-1:0] hold_ff, hold_in;
   logic signed [WORD_W-1:0] rd_ff;
   rsp_item_type             rsp_ff, rsp_in;

   logic                     we;
   logic [AW-1:0]            waddr, raddr;
   logic signed [WORD_W-1:0] wdata;
   logic                     less;
   logic [AW-1:0]            top_addr;

   assign top_addr = AW'(count_ff - CW'(1));
   assign less     = hold_ff < rd_ff;

   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.empty       = (count_ff == '0);
   assign stat.short_stack = (count_ff < CW'(2));
   assign stat.j_last      = (j_ff == top_addr);
   assign stat.i_last      = (i_ff == AW'(count_ff - CW'(2)));

   always_comb begin
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      hold_in  = hold_ff;
      we       = 1'b0;
      waddr    = '0;
      wdata    = hold_ff;
      raddr    = top_addr;
      rsp_in   = rsp_ff;

      if (cmd.push_wr) begin
         we       = 1'b1;
         waddr    = AW'(count_ff);
         wdata    = req_data.push_value;
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_rd) begin
         raddr    = top_addr;
         count_in = count_ff - CW'(1);
      end
      if (cmd.sort_init) begin
         i_in  = '0;
         raddr = '0;
      end
      if (cmd.hold_load) begin
         hold_in = rd_ff;
         j_in    = i_ff + AW'(1);
         raddr   = i_ff + AW'(1);
      end
      if (cmd.cmp_step) begin
         if (less) begin
            we      = 1'b1;
            waddr   = j_ff;
            wdata   = hold_ff;
            hold_in = rd_ff;
         end
         j_in  = j_ff + AW'(1);
         raddr = j_ff + AW'(1);
      end
      if (cmd.wb_step) begin
         we    = 1'b1;
         waddr = i_ff;
         wdata = hold_ff;
         i_in  = i_ff + AW'(1);
         raddr = i_ff + AW'(1);
      end

      if (cmd.rsp_now) begin
         rsp_in.pop_value = '0;
         rsp_in.status    = ST_OK;
         case (req_data.req_type)
            REQ_PUSH: begin
               if (stat.full) rsp_in.status = ST_FULL;
            end
            REQ_POP: begin
               rsp_in.pop_value = -32'sd1;
               rsp_in.status    = ST_EMPTY;
            end
            default: ;
         endcase
      end else if (cmd.rsp_pop) begin
         rsp_in.pop_value = rd_ff;
         rsp_in.status    = ST_OK;
      end else if (cmd.rsp_done) begin
         rsp_in.pop_value = '0;
         rsp_in.status    = ST_OK;
      end
      if (cmd.rsp_now || cmd.rsp_pop || cmd.rsp_done) begin
         rsp_in.fill_level = FILL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      i_ff    <= i_in;
      j_ff    <= j_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/sstk_ctrl.sv
// sortable stack controller: request sequencing and handshakes
module sstk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sstk_pkg::sstk_stat_type stat,
   output sstk_pkg::sstk_cmd_type  cmd
);
   import sstk_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_POP  = 5'b00010,
      S_SI   = 5'b00100,
      S_SJ   = 5'b01000,
      S_WB   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_load;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_code)
                  REQ_PUSH: begin
                     cmd.push_wr = !stat.full;
                     cmd.rsp_now = 1'b1;
                  end
                  REQ_POP: begin
                     if (stat.empty) begin
                        cmd.rsp_now = 1'b1;
                     end else begin
                        cmd.pop_rd = 1'b1;
                        state_in   = S_POP;
                     end
                  end
                  REQ_SORT: begin
                     if (stat.short_stack) begin
                        cmd.rsp_now = 1'b1;
                     end else begin
                        cmd.sort_init = 1'b1;
                        state_in      = S_SI;
                     end
                  end
                  default: cmd.rsp_now = 1'b1;
               endcase
            end
         end
         S_POP: begin
            cmd.rsp_pop = 1'b1;
            state_in    = S_IDLE;
         end
         S_SI: begin
            cmd.hold_load = 1'b1;
            state_in      = S_SJ;
         end
         S_SJ: begin
            cmd.cmp_step = 1'b1;
            if (stat.j_last) state_in = S_WB;
         end
         S_WB: begin
            cmd.wb_step = 1'b1;
            if (stat.i_last) begin
               cmd.rsp_done = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_SI;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_load = cmd.rsp_now || cmd.rsp_pop || cmd.rsp_done;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load)  rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/sortable_stack_core.sv
// sortable stack top level: bounded lifo of signed words with in-place exchange sort
//
// usage
//  - req channel (valid/ready) carries a request code and a push word; rsp channel
//    (valid/ready) returns one result per request: word, status and fill count
//  - push, a refused push, a pop on empty, a sort of fewer than two entries and the
//    unused code all finish in the accept cycle; the result shows in the next cycle
//  - a pop reads the entry memory through its registered read port, so its result
//    passes through the read register and then the result register
//  - a sort of n entries steps through outer positions 0 to n-2 after the accept cycle:
//    each outer position takes a read step, a compare step per later entry and a
//    write-back step, all through the single read and write port of the memory
//  - one request is in work at a time; req_ready is high while idle and the result
//    register is empty or being taken in the same cycle
//  - a stalled receiver holds the result in the output register and blocks new
//    requests until the transfer completes
//  - reset (synchronous, active high) empties the stack and drops any pending
//    result; memory contents are not cleared
module sortable_stack_core #(
   parameter int DEPTH = sstk_pkg::DEFAULT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sstk_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sstk_pkg::rsp_item_type rsp_data
);
   import sstk_pkg::*;

   // command and status between sequencer and datapath
   sstk_cmd_type  cmd;
   sstk_stat_type stat;

   // request sequencing and both handshakes
   sstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry memory, fill count, sort indexes and result payload
   sstk_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench for the sortable stack core: every response transfer is checked against a predicted stack
module testbench;
   import sstk_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int IDLE_PCT    = 37;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 300;
   // settle time after the last result, longer than a sort of a full stack
   localparam int TAIL_CYCLES = 200;
   // request code with no operation behind it
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   // predicted stack contents and fill count
   logic signed [WORD_W-1:0] stack_words [DEPTH];
   int                       stack_fill = 0;

   rsp_item_type pending_results [$];
   int           error_count   = 0;
   int           items_sent    = 0;
   bit           idle_on       = 1'b1;
   int           hold_request  = 0;
   int           hold_left     = 0;

   sortable_stack_core #(
      .DEPTH(DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted result of one accepted request; updates the predicted stack
   function automatic rsp_item_type apply_request(input req_item_type item);
      rsp_item_type             rsp;
      logic signed [WORD_W-1:0] swap;
      int                       i;
      int                       j;
      rsp.pop_value = '0;
      rsp.status    = ST_OK;
      case (item.req_type)
         REQ_PUSH: begin
            // full stack drops the word
            if (stack_fill >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               stack_words[stack_fill] = item.push_value;
               stack_fill++;
            end
         end
         REQ_POP: begin
            if (stack_fill == 0) begin
               rsp.pop_value = -1;
               rsp.status    = ST_EMPTY;
            end else begin
               stack_fill--;
               rsp.pop_value = stack_words[stack_fill];
            end
         end
         REQ_SORT: begin
            // exchange sort, largest at the bottom; equal words stay put
            for (i = 0; i < stack_fill; i++) begin
               for (j = i + 1; j < stack_fill; j++) begin
                  if (stack_words[i] < stack_words[j]) begin
                     swap           = stack_words[i];
                     stack_words[i] = stack_words[j];
                     stack_words[j] = swap;
                  end
               end
            end
         end
         default: begin
            // unused code changes nothing
         end
      endcase
      rsp.fill_level = FILL_W'(stack_fill);
      return rsp;
   endfunction

   // mix of extremes, small values that repeat, and full-range words
   function automatic logic signed [WORD_W-1:0] random_word();
      logic signed [WORD_W-1:0] word;
      case ($urandom_range(9))
         0: word = 32'sh7FFF_FFFF;
         1: word = 32'sh8000_0000;
         2: word = 0;
         3: word = -1;
         4, 5: word = $signed($urandom_range(0, 6)) - 3;
         default: word = $urandom;
      endcase
      return word;
   endfunction

   // response receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker: each transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response transfer: value %0d status %0d fill %0d",
                        rsp_data.pop_value, rsp_data.status, rsp_data.fill_level);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.pop_value !== want.pop_value || rsp_data.status !== want.status ||
                rsp_data.fill_level !== want.fill_level) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: expected value %0d status %0d fill %0d, got %0d %0d %0d",
                           want.pop_value, want.status, want.fill_level,
                           rsp_data.pop_value, rsp_data.status, rsp_data.fill_level);
            end
         end
      end
   end

   // offer one request, wait for its transfer and record the predicted result
   task automatic send_request(input logic [1:0] kind, input logic signed [WORD_W-1:0] word);
      req_item_type item;
      item.req_type   = kind;
      item.push_value = word;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_request(item));
      items_sent++;
   endtask

   // sender pause until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // mostly fill / sort / drain sequences with random content, some noise
   task automatic run_stack_traffic(input int n_items);
      int start;
      int n_push;
      int n_pop;
      start = items_sent;
      while (items_sent - start < n_items) begin
         if ($urandom_range(99) < 75) begin
            n_push = ($urandom_range(5) == 0) ? DEPTH + 2 : $urandom_range(0, DEPTH);
            repeat (n_push) send_request(REQ_PUSH, random_word());
            if ($urandom_range(2) != 0) send_request(REQ_SORT, $urandom);
            if ($urandom_range(5) == 0) send_request(REQ_UNUSED, $urandom);
            n_pop = ($urandom_range(4) == 0) ? stack_fill + 2 : $urandom_range(0, stack_fill);
            repeat (n_pop) send_request(REQ_POP, $urandom);
         end else begin
            repeat ($urandom_range(1, 8)) send_request(2'($urandom_range(0, 3)), random_word());
         end
      end
   endtask

   // extremes, every request code, empty pop, short sorts, equal words
   task automatic test_directed();
      send_request(REQ_POP, 32'sh7FFF_FFFF);
      send_request(REQ_SORT, -1);
      send_request(REQ_UNUSED, 32'sh7FFF_FFFF);
      send_request(REQ_PUSH, 32'sh7FFF_FFFF);
      send_request(REQ_SORT, 0);
      send_request(REQ_PUSH, 32'sh8000_0000);
      send_request(REQ_PUSH, -1);
      send_request(REQ_PUSH, 0);
      send_request(REQ_PUSH, -1);
      send_request(REQ_PUSH, 1);
      send_request(REQ_SORT, 32'sh8000_0000);
      send_request(REQ_UNUSED, 32'sh8000_0000);
      repeat (6) send_request(REQ_POP, 0);
      wait_for_results();
   endtask

   // fill up, refused pushes, sort of a full stack, drain past empty
   task automatic test_full_stack();
      repeat (DEPTH) send_request(REQ_PUSH, random_word());
      repeat (2) send_request(REQ_PUSH, random_word());
      send_request(REQ_SORT, $urandom);
      repeat (DEPTH + 1) send_request(REQ_POP, $urandom);
      wait_for_results();
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      run_stack_traffic(40);
      wait_for_results();
   endtask

   // both sides at full rate
   task automatic test_no_idle();
      idle_on = 1'b0;
      run_stack_traffic(250);
      wait_for_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random();
      run_stack_traffic(1250);
      wait_for_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_stack();
      test_backpressure();
      test_no_idle();
      test_random();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // timeout
   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
src/sstk_pkg.sv
src/sstk_dp.sv
src/sstk_ctrl.sv
src/sortable_stack_core.sv
sim/testbench.sv
